// ===== src/dmm_pkg.sv =====
`timescale 1ns / 1ps

package dmm_pkg;

    localparam logic [31:0] PERIOD_RESET = 32'd1000000;
    localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_WAKEUP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_LATE,
        S_DIV,
        S_MUL,
        S_ADV,
        S_DEAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic update;
    } t_stat_cmd;

    typedef struct packed {
        logic [31:0] cycle;
        logic [31:0] late_cycles;
        logic [31:0] missed_sum;
    } t_counters;

endpackage

// ===== src/dmm_if.sv =====
`timescale 1ns / 1ps

interface dmm_in_if #(
    parameter int TIME_BITS = 63
);
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [TIME_BITS-1:0] event_time;
    logic [31:0]          execution_time;

    modport source (output valid, op, event_time, execution_time, input ready);
    modport sink (input valid, op, event_time, execution_time, output ready);
endinterface

interface dmm_out_if #(
    parameter int TIME_BITS = 63
);
    logic                 valid;
    logic                 ready;
    logic [31:0]          cycle_index;
    logic [TIME_BITS-1:0] due_time;
    logic [TIME_BITS-1:0] lateness;
    logic [31:0]          missed_count;
    logic [31:0]          late_cycle_total;
    logic [31:0]          missed_period_total;
    logic [TIME_BITS-1:0] min_late;
    logic [TIME_BITS-1:0] max_late;
    logic [31:0]          min_exec;
    logic [31:0]          max_exec;

    modport source (
        output valid, cycle_index, due_time, lateness, missed_count, late_cycle_total,
               missed_period_total, min_late, max_late, min_exec, max_exec,
        input  ready
    );
    modport sink (
        input  valid, cycle_index, due_time, lateness, missed_count, late_cycle_total,
               missed_period_total, min_late, max_late, min_exec, max_exec,
        output ready
    );
endinterface

// ===== src/dmm_div.sv =====
`timescale 1ns / 1ps

module dmm_div #(
    parameter int TIME_BITS = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [TIME_BITS-1:0] i_dividend,
    input  logic [31:0]          i_divisor,
    output logic                 o_done,
    output logic [TIME_BITS-1:0] o_quot
);

    localparam int CW = $clog2(TIME_BITS);
    localparam logic [CW-1:0] LAST = CW'(TIME_BITS - 1);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [31:0]          r_rem;
    logic [TIME_BITS-1:0] r_quot;
    logic [31:0]          r_div;

    logic [32:0] w_shift;
    logic        w_ge;
    logic [32:0] w_diff;

    assign w_shift = {r_rem, r_quot[TIME_BITS-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign o_done  = r_busy && (r_cnt == LAST);
    assign o_quot  = {r_quot[TIME_BITS-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[31:0] : w_shift[31:0];
            r_quot <= {r_quot[TIME_BITS-2:0], w_ge};
        end
    end

endmodule

// ===== src/dmm_stats.sv =====
`timescale 1ns / 1ps

module dmm_stats
    import dmm_pkg::*;
#(
    parameter int TIME_BITS = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_stat_cmd            i_cmd,
    input  logic [TIME_BITS-1:0] i_late,
    input  logic [31:0]          i_exec,
    input  logic [31:0]          i_missed,
    output t_counters            o_cnt,
    output logic [TIME_BITS-1:0] o_min_late,
    output logic [TIME_BITS-1:0] o_max_late,
    output logic [31:0]          o_min_exec,
    output logic [31:0]          o_max_exec
);

    t_counters            r_cnt;
    logic [TIME_BITS-1:0] r_min_late;
    logic [TIME_BITS-1:0] r_max_late;
    logic [31:0]          r_min_exec;
    logic [31:0]          r_max_exec;
    logic                 r_seeded;

    logic [32:0] w_sum;

    assign w_sum = {1'b0, r_cnt.missed_sum} + {1'b0, i_missed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt      <= '0;
            r_min_late <= '0;
            r_max_late <= '0;
            r_min_exec <= '0;
            r_max_exec <= '0;
            r_seeded   <= 1'b0;
        end else if (i_cmd.update) begin
            r_seeded <= 1'b1;
            if (!r_seeded || i_late < r_min_late) begin
                r_min_late <= i_late;
            end
            if (!r_seeded || i_late > r_max_late) begin
                r_max_late <= i_late;
            end
            if (!r_seeded || i_exec < r_min_exec) begin
                r_min_exec <= i_exec;
            end
            if (!r_seeded || i_exec > r_max_exec) begin
                r_max_exec <= i_exec;
            end
            if (r_cnt.cycle != CNT_MAX) begin
                r_cnt.cycle <= r_cnt.cycle + 32'd1;
            end
            r_cnt.missed_sum <= w_sum[32] ? CNT_MAX : w_sum[31:0];
            if (i_missed != '0 && r_cnt.late_cycles != CNT_MAX) begin
                r_cnt.late_cycles <= r_cnt.late_cycles + 32'd1;
            end
        end
    end

    assign o_cnt      = r_cnt;
    assign o_min_late = r_min_late;
    assign o_max_late = r_max_late;
    assign o_min_exec = r_min_exec;
    assign o_max_exec = r_max_exec;

endmodule

// ===== src/deadline_miss_monitor.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// i_in      in   valid/ready        op, event_time, execution_time
// o_out     out  valid/ready        cycle_index .. max_exec, one item per wakeup
// i_cfg_*   in   write enable only  period_ns
//
// A start item passes through S_START; a wakeup item passes through S_LATE,
// S_DIV (the bit-serial divider that forms the missed count), S_MUL, S_ADV,
// S_DEAD and S_OUT. One item is in flight at a time; the next input item is
// taken while a result still waits in the output register, and a wakeup waits
// at its end for that register to drain. Reset is synchronous and active low
// and clears the deadline, the statistics and the period (to 1 ms).

module deadline_miss_monitor
    import dmm_pkg::*;
#(
    parameter int TIME_BITS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmm_in_if.sink      i_in,
    dmm_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    t_state r_state;
    t_state n_state;

    logic [31:0]          r_period;
    logic [TIME_BITS-1:0] r_deadline;
    logic [TIME_BITS-1:0] r_t;
    logic [31:0]          r_exec;
    logic [TIME_BITS-1:0] r_late;
    logic [31:0]          r_missed;
    logic [31:0]          r_idx;
    logic [TIME_BITS-1:0] r_due;
    logic [63:0]          r_prod;
    logic [63:0]          r_adv;

    logic                 r_out_valid;
    logic [31:0]          r_o_idx;
    logic [TIME_BITS-1:0] r_o_due;
    logic [TIME_BITS-1:0] r_o_late;
    logic [31:0]          r_o_missed;
    t_counters            r_o_cnt;
    logic [TIME_BITS-1:0] r_o_min_late;
    logic [TIME_BITS-1:0] r_o_max_late;
    logic [31:0]          r_o_min_exec;
    logic [31:0]          r_o_max_exec;

    logic [31:0]          w_eff;
    logic [TIME_BITS:0]   w_start_sum;
    logic [TIME_BITS-1:0] w_late;
    logic [63:0]          w_quot;
    logic [63:0]          w_prod;
    logic [64:0]          w_dead_sum;
    logic                 w_in_ready;
    logic                 w_accept;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [TIME_BITS-1:0] w_div_quot;
    logic                 w_load;
    t_stat_cmd            w_cmd;

    t_counters            w_cnt;
    logic [TIME_BITS-1:0] w_min_late;
    logic [TIME_BITS-1:0] w_max_late;
    logic [31:0]          w_min_exec;
    logic [31:0]          w_max_exec;

    assign w_eff       = (r_period == '0) ? 32'd1 : r_period;
    assign w_start_sum = {1'b0, r_t} + (TIME_BITS + 1)'(w_eff);
    assign w_late      = (r_t > r_deadline) ? (r_t - r_deadline) : '0;
    assign w_quot      = 64'(w_div_quot);
    assign w_prod      = 64'(w_eff) * 64'(r_missed);
    assign w_dead_sum  = 65'(r_deadline) + {1'b0, r_adv};
    assign w_accept    = i_in.valid && w_in_ready;
    assign i_in.ready  = w_in_ready;

    dmm_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_late),
        .i_divisor  (w_eff),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    dmm_stats #(
        .TIME_BITS (TIME_BITS)
    ) u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_late     (r_late),
        .i_exec     (r_exec),
        .i_missed   (r_missed),
        .o_cnt      (w_cnt),
        .o_min_late (w_min_late),
        .o_max_late (w_max_late),
        .o_min_exec (w_min_exec),
        .o_max_exec (w_max_exec)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.op == OP_START) ? S_START : S_LATE;
                end
            end
            S_START: n_state = S_IDLE;
            S_LATE:  n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_ADV;
            S_ADV:  n_state = S_DEAD;
            S_DEAD: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_cmd       = '0;
        w_load      = 1'b0;
        case (r_state)
            S_IDLE:  w_in_ready  = 1'b1;
            S_START: w_cmd.clear = 1'b1;
            S_LATE:  w_div_start = 1'b1;
            S_MUL:   w_cmd.update = 1'b1;
            S_OUT:   w_load = !r_out_valid || o_out.ready;
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RESET;
            r_deadline  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_state == S_START) begin
                r_deadline <= w_start_sum[TIME_BITS] ? TIME_MAX : w_start_sum[TIME_BITS-1:0];
            end else if (r_state == S_DEAD) begin
                r_deadline <= (w_dead_sum > 65'(TIME_MAX)) ? TIME_MAX
                                                           : w_dead_sum[TIME_BITS-1:0];
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_t    <= i_in.event_time;
            r_exec <= i_in.execution_time;
        end
        if (r_state == S_LATE) begin
            r_late <= w_late;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_missed <= (w_quot[63:32] != '0) ? CNT_MAX : w_quot[31:0];
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
            r_idx  <= w_cnt.cycle;
        end
        if (r_state == S_ADV) begin
            r_adv <= r_prod + 64'(w_eff);
        end
        if (r_state == S_DEAD) begin
            r_due <= r_deadline;
        end
        if (w_load) begin
            r_o_idx      <= r_idx;
            r_o_due      <= r_due;
            r_o_late     <= r_late;
            r_o_missed   <= r_missed;
            r_o_cnt      <= w_cnt;
            r_o_min_late <= w_min_late;
            r_o_max_late <= w_max_late;
            r_o_min_exec <= w_min_exec;
            r_o_max_exec <= w_max_exec;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.cycle_index         = r_o_idx;
    assign o_out.due_time            = r_o_due;
    assign o_out.lateness            = r_o_late;
    assign o_out.missed_count        = r_o_missed;
    assign o_out.late_cycle_total    = r_o_cnt.late_cycles;
    assign o_out.missed_period_total = r_o_cnt.missed_sum;
    assign o_out.min_late            = r_o_min_late;
    assign o_out.max_late            = r_o_max_late;
    assign o_out.min_exec            = r_o_min_exec;
    assign o_out.max_exec            = r_o_max_exec;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_missed_vs_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_o_missed == '0) == (64'(r_o_late) < 64'(w_eff))))
        else $error("missed count disagrees with lateness and period");

    a_totals_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_o_cnt.late_cycles <= r_o_cnt.missed_sum)
        else $error("late cycle total exceeds missed period total");

    a_extremes_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_min_late <= r_o_max_late) && (r_o_min_exec <= r_o_max_exec))
        else $error("minimum exceeds maximum in reported statistics");

endmodule

// ===== verif/deadline_miss_monitor_tb.sv =====
`timescale 1ns / 1ps

module deadline_miss_monitor_tb;
    import dmm_pkg::*;

    localparam int TB_TIME_BITS    = 63;
    localparam int SETTLE_CYCLES   = 90;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 120;

    typedef logic [TB_TIME_BITS-1:0] stamp_t;

    localparam stamp_t TIME_MAX = '1;

    typedef struct packed {
        logic [31:0] cycle_index;
        stamp_t      due_time;
        stamp_t      lateness;
        logic [31:0] missed_count;
        logic [31:0] late_cycle_total;
        logic [31:0] missed_period_total;
        stamp_t      min_late;
        stamp_t      max_late;
        logic [31:0] min_exec;
        logic [31:0] max_exec;
    } report_t;

    localparam report_t NO_REPORT = '0;

    typedef enum logic {
        ENTRY_PERIOD,
        ENTRY_ITEM
    } entry_kind_e;

    typedef struct {
        entry_kind_e kind;
        logic        op;
        stamp_t      stamp;
        logic [31:0] exec;
        logic [31:0] period;
        bit          typed;
        report_t     want;
    } stimulus_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    dmm_in_if  #(.TIME_BITS(TB_TIME_BITS)) in_ch ();
    dmm_out_if #(.TIME_BITS(TB_TIME_BITS)) out_ch ();

    deadline_miss_monitor #(
        .TIME_BITS(TB_TIME_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the monitor state and its one register.
    logic [31:0] period_reg;
    stamp_t      next_due;
    logic [31:0] cycle_cnt;
    logic [31:0] late_cnt;
    logic [31:0] missed_total;
    stamp_t      low_late;
    stamp_t      high_late;
    logic [31:0] low_exec;
    logic [31:0] high_exec;
    bit          seeded;

    report_t due_reports[$];
    bit      hand_typed;
    report_t hand_report;

    int mismatches;
    int results_checked;
    int late_results;
    int items_sent;
    int starts_sent;
    int period_writes;
    int quiet_cycles;
    int in_gap_rate;
    int out_stall_rate;
    int stall_left;
    bit hold_request;

    function automatic logic [31:0] sat32_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? CNT_MAX : s[31:0];
    endfunction

    function automatic stamp_t sat_stamp_add(input stamp_t a, input logic [65:0] b);
        logic [66:0] s;
        s = 67'(a) + 67'(b);
        return (s > 67'(TIME_MAX)) ? TIME_MAX : s[TB_TIME_BITS-1:0];
    endfunction

    function automatic void clear_stats();
        cycle_cnt    = '0;
        late_cnt     = '0;
        missed_total = '0;
        low_late     = '0;
        high_late    = '0;
        low_exec     = '0;
        high_exec    = '0;
        seeded       = 1'b0;
    endfunction

    function automatic void predict_report(input logic op, input stamp_t stamp,
                                           input logic [31:0] exec, output bit produced,
                                           output report_t rep);
        logic [32:0] per;
        stamp_t      late;
        stamp_t      quot;
        logic [31:0] missed;
        logic [65:0] adv;
        per      = (period_reg == '0) ? 33'd1 : {1'b0, period_reg};
        produced = 1'b0;
        rep      = NO_REPORT;
        if (op == OP_START) begin
            next_due = sat_stamp_add(stamp, 66'(per));
            clear_stats();
            return;
        end
        late   = (stamp > next_due) ? stamp - next_due : '0;
        quot   = late / TB_TIME_BITS'(per);
        missed = (quot > TB_TIME_BITS'(CNT_MAX)) ? CNT_MAX : quot[31:0];
        if (!seeded) begin
            low_late  = late;
            high_late = late;
            low_exec  = exec;
            high_exec = exec;
            seeded    = 1'b1;
        end else begin
            if (late < low_late) low_late = late;
            if (late > high_late) high_late = late;
            if (exec < low_exec) low_exec = exec;
            if (exec > high_exec) high_exec = exec;
        end
        rep.cycle_index  = cycle_cnt;
        rep.due_time     = next_due;
        rep.lateness     = late;
        rep.missed_count = missed;
        cycle_cnt        = sat32_sum(cycle_cnt, 32'd1);
        missed_total     = sat32_sum(missed_total, missed);
        if (missed != '0) late_cnt = sat32_sum(late_cnt, 32'd1);
        adv      = 66'(per) * 66'({1'b0, missed} + 33'd1);
        next_due = sat_stamp_add(next_due, adv);
        rep.late_cycle_total    = late_cnt;
        rep.missed_period_total = missed_total;
        rep.min_late            = low_late;
        rep.max_late            = high_late;
        rep.min_exec            = low_exec;
        rep.max_exec            = high_exec;
        produced = 1'b1;
    endfunction

    function automatic void note_field(input string label, input logic [63:0] want,
                                       input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %h, got %h", results_checked, label, want, got);
            end
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        bit      produced;
        report_t rep;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_report(in_ch.op, in_ch.event_time, in_ch.execution_time, produced, rep);
            if (produced) due_reports.push_back(hand_typed ? hand_report : rep);
        end
    end

    always @(posedge i_clk) begin
        report_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing expected", results_checked);
                end
            end else begin
                want = due_reports.pop_front();
                note_field("cycle_index", 64'(want.cycle_index), 64'(out_ch.cycle_index));
                note_field("due_time", 64'(want.due_time), 64'(out_ch.due_time));
                note_field("lateness", 64'(want.lateness), 64'(out_ch.lateness));
                note_field("missed_count", 64'(want.missed_count), 64'(out_ch.missed_count));
                note_field("late_cycle_total", 64'(want.late_cycle_total),
                           64'(out_ch.late_cycle_total));
                note_field("missed_period_total", 64'(want.missed_period_total),
                           64'(out_ch.missed_period_total));
                note_field("min_late", 64'(want.min_late), 64'(out_ch.min_late));
                note_field("max_late", 64'(want.max_late), 64'(out_ch.max_late));
                note_field("min_exec", 64'(want.min_exec), 64'(out_ch.min_exec));
                note_field("max_exec", 64'(want.max_exec), 64'(out_ch.max_exec));
                if (want.missed_count != '0) late_results++;
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls in random bursts, and once for a long stretch on request.
    initial begin
        out_ch.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (out_stall_rate > 0 && $urandom_range(0, 99) < out_stall_rate) begin
                stall_left = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic op, input stamp_t stamp, input logic [31:0] exec,
                             input bit typed, input report_t want);
        hand_typed  = typed;
        hand_report = want;
        in_ch.valid          <= 1'b1;
        in_ch.op             <= op;
        in_ch.event_time     <= stamp;
        in_ch.execution_time <= exec;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
        if (op == OP_START) starts_sent++;
        if (in_gap_rate > 0 && $urandom_range(0, 99) < in_gap_rate) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_period(input logic [31:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we     <= 1'b0;
        period_reg = value;
        period_writes++;
    endtask

    initial begin
        stimulus_row_t rows[$];
        logic [31:0]   new_period;
        logic [31:0]   eff_per;
        logic [31:0]   exec;
        logic [31:0]   d;
        logic [64:0]   wide;
        stamp_t        stamp;
        int            r;

        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.op             <= OP_START;
        in_ch.event_time     <= '0;
        in_ch.execution_time <= '0;
        hand_typed     = 1'b0;
        hand_report    = NO_REPORT;
        in_gap_rate    = 0;
        out_stall_rate = 0;
        hold_request   = 1'b0;
        period_reg     = PERIOD_RESET;
        next_due       = '0;
        clear_stats();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd5000, 32'd7, 32'd0, 1'b1,
            '{32'd0, 63'd0, 63'd5000, 32'd0, 32'd0, 32'd0, 63'd5000, 63'd5000, 32'd7, 32'd7}});
        rows.push_back('{ENTRY_ITEM, OP_START, 63'd0, 32'd0, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd1000000, 32'd0, 32'd0, 1'b1,
            '{32'd0, 63'd1000000, 63'd0, 32'd0, 32'd0, 32'd0, 63'd0, 63'd0, 32'd0, 32'd0}});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd1500000, CNT_MAX, 32'd0, 1'b1,
            '{32'd1, 63'd2000000, 63'd0, 32'd0, 32'd0, 32'd0, 63'd0, 63'd0, 32'd0, CNT_MAX}});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd5500000, 32'd100, 32'd0, 1'b1,
            '{32'd2, 63'd3000000, 63'd2500000, 32'd2, 32'd1, 32'd2, 63'd0, 63'd2500000,
              32'd0, CNT_MAX}});
        rows.push_back('{ENTRY_ITEM, OP_START, TIME_MAX, 32'd0, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, TIME_MAX, 32'd5, 32'd0, 1'b1,
            '{32'd0, TIME_MAX, 63'd0, 32'd0, 32'd0, 32'd0, 63'd0, 63'd0, 32'd5, 32'd5}});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd0, 32'd9, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_START, 63'd0, 32'd0, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, TIME_MAX, 32'd3, 32'd0, 1'b1,
            '{32'd0, 63'd1000000, 63'h7FFF_FFFF_FFF0_BDBF, CNT_MAX, 32'd1, CNT_MAX,
              63'h7FFF_FFFF_FFF0_BDBF, 63'h7FFF_FFFF_FFF0_BDBF, 32'd3, 32'd3}});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, TIME_MAX, 32'd4, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_PERIOD, OP_START, 63'd0, 32'd0, 32'd1, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_START, 63'd10, 32'd0, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd11, 32'd1, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd100, 32'd2, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_PERIOD, OP_START, 63'd0, 32'd0, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_START, TIME_MAX - 63'd1, 32'd0, 32'd0, 1'b0,
                         NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, TIME_MAX, 32'd0, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_PERIOD, OP_START, 63'd0, 32'd0, CNT_MAX, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_START, TIME_MAX - 63'd5, 32'd0, 32'd0, 1'b0,
                         NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, 63'd0, 32'd8, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_START, 63'd0, 32'd0, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, TIME_MAX, CNT_MAX, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_ITEM, OP_WAKEUP, TIME_MAX, 32'd1, 32'd0, 1'b0, NO_REPORT});
        rows.push_back('{ENTRY_PERIOD, OP_START, 63'd0, 32'd0, PERIOD_RESET, 1'b0,
                         NO_REPORT});

        foreach (rows[i]) begin
            if (rows[i].kind == ENTRY_PERIOD) begin
                write_period(rows[i].period);
            end else begin
                send_item(rows[i].op, rows[i].stamp, rows[i].exec, rows[i].typed,
                          rows[i].want);
            end
        end

        // Random phases: mostly a start followed by wakeups around the running
        // deadline, mixed with late, very late and arbitrary timestamps.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: new_period = PERIOD_RESET;
                1: new_period = 32'd1;
                2: new_period = CNT_MAX;
                3: new_period = 32'd0;
                default: begin
                    r = $urandom_range(0, 2);
                    if (r == 0) new_period = $urandom_range(1, 2000);
                    else if (r == 1) new_period = $urandom;
                    else new_period = $urandom_range(1000, 10000000);
                end
            endcase
            write_period(new_period);
            if (ph == PHASES - 1) begin
                in_gap_rate    = 0;
                out_stall_rate = 0;
            end else if (ph == 2) begin
                in_gap_rate    = 0;
                out_stall_rate = 0;
                hold_request   = 1'b1;
            end else begin
                r = $urandom_range(0, 2);
                in_gap_rate = (r == 0) ? 0 : ((r == 1) ? 10 : 35);
                r = $urandom_range(0, 2);
                out_stall_rate = (r == 0) ? 0 : ((r == 1) ? 10 : 35);
            end
            eff_per = (period_reg == '0) ? 32'd1 : period_reg;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 70) exec = $urandom_range(0, 100000);
                else if (r < 85) exec = $urandom;
                else if (r < 92) exec = '0;
                else exec = CNT_MAX;

                r = $urandom_range(0, 99);
                if ((k == 0 && r < 90) || (k > 0 && r < 4)) begin
                    r = $urandom_range(0, 99);
                    if (r < 60) stamp = TB_TIME_BITS'({$urandom_range(0, 1023), $urandom});
                    else if (r < 85) stamp = TB_TIME_BITS'({$urandom, $urandom});
                    else stamp = TIME_MAX - TB_TIME_BITS'($urandom_range(0, 5000));
                    send_item(OP_START, stamp, exec, 1'b0, NO_REPORT);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 45) begin
                        wide = 65'(next_due) + 65'($urandom_range(0, eff_per >> 2));
                    end else if (r < 60) begin
                        d = $urandom_range(0, eff_per);
                        wide = (next_due > TB_TIME_BITS'(d)) ? 65'(next_due - d) : '0;
                    end else if (r < 80) begin
                        wide = 65'(next_due) + 65'(eff_per) * 65'($urandom_range(1, 6))
                               + 65'($urandom_range(0, eff_per - 32'd1));
                    end else if (r < 92) begin
                        wide = 65'(next_due)
                               + (65'({$urandom, $urandom}) >> $urandom_range(0, 40));
                    end else begin
                        wide = 65'({$urandom, $urandom}) & 65'(TIME_MAX);
                    end
                    stamp = (wide > 65'(TIME_MAX)) ? TIME_MAX : wide[TB_TIME_BITS-1:0];
                    send_item(OP_WAKEUP, stamp, exec, 1'b0, NO_REPORT);
                end
            end
        end

        wait_quiet();
        if (due_reports.size() != 0) begin
            mismatches += due_reports.size();
            $display("%0d expected results never arrived", due_reports.size());
        end

        $display("Sent %0d items (%0d starts) over %0d period settings; %0d results checked.",
                 items_sent, starts_sent, period_writes, results_checked);
        $display("%0d results had missed periods; periods included 0, 1 and 2^32-1.",
                 late_results);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
